// File: src/rfe_pkg.sv
`timescale 1ns / 1ps

package rfe_pkg;

  localparam int DATA_W        = 32;
  localparam int CMD_W         = 4;
  localparam int IDX_W         = 4;
  localparam int REG_COUNT_DEF = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD       = 4'd0;
  localparam logic [CMD_W-1:0] CMD_ADD        = 4'd1;
  localparam logic [CMD_W-1:0] CMD_SUB        = 4'd2;
  localparam logic [CMD_W-1:0] CMD_MUL        = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DIV        = 4'd4;
  localparam logic [CMD_W-1:0] CMD_NOT        = 4'd5;
  localparam logic [CMD_W-1:0] CMD_EQUAL      = 4'd6;
  localparam logic [CMD_W-1:0] CMD_LESS       = 4'd7;
  localparam logic [CMD_W-1:0] CMD_LESS_EQUAL = 4'd8;

endpackage

// File: src/rfe_regfile.sv
`timescale 1ns / 1ps

module rfe_regfile
  import rfe_pkg::*;
#(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [$clog2(REG_COUNT)-1:0] rd_addr_a,
  input  logic [$clog2(REG_COUNT)-1:0] rd_addr_b,
  output logic [DATA_W-1:0]            rd_data_a,
  output logic [DATA_W-1:0]            rd_data_b,
  input  logic                         wr_en,
  input  logic [$clog2(REG_COUNT)-1:0] wr_addr,
  input  logic [DATA_W-1:0]            wr_data
);

  logic [DATA_W-1:0]    mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  logic [DATA_W-1:0]    q_a_r;
  logic [DATA_W-1:0]    q_b_r;
  logic [DATA_W-1:0]    fwd_data_r;
  logic                 fwd_a_r;
  logic                 fwd_b_r;
  logic                 live_a_r;
  logic                 live_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_a_r      <= mem[rd_addr_a];
    q_b_r      <= mem[rd_addr_b];
    fwd_data_r <= wr_data;
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      fwd_a_r  <= 1'b0;
      fwd_b_r  <= 1'b0;
      live_a_r <= 1'b0;
      live_b_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      // forward a write that lands on the entry read in the same cycle
      fwd_a_r  <= wr_en && (wr_addr == rd_addr_a);
      fwd_b_r  <= wr_en && (wr_addr == rd_addr_b);
      live_a_r <= valid_r[rd_addr_a];
      live_b_r <= valid_r[rd_addr_b];
    end
  end

  assign rd_data_a = fwd_a_r ? fwd_data_r : (live_a_r ? q_a_r : '0);
  assign rd_data_b = fwd_b_r ? fwd_data_r : (live_b_r ? q_b_r : '0);

endmodule

// File: src/rfe_divider.sv
`timescale 1ns / 1ps

module rfe_divider
  import rfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              run_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] div_r;
  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] diff;

  // one quotient bit per cycle, restoring
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (run_r) begin
      if (!diff[DATA_W+1]) begin
        rem_r <= diff[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: src/register_file_alu_execute.sv
`timescale 1ns / 1ps

// Register-machine execute stage on a file of REG_COUNT 32-bit words.
// Input channel: present in_command, in_src_a, in_src_b, in_dest and
// in_literal with start high; the instruction is taken at a rising edge where
// start is high and busy is low. Register indexes wrap modulo REG_COUNT.
// Result channel: out_valid is high for exactly one cycle per instruction,
// carrying out_written_value, out_bad_command and out_divide_by_zero.
// The receiver cannot stall; every result must be taken in its cycle.
// Every command except a divide with nonzero divisor is evaluated in the
// execute state and its result beat is registered from there; such a divide
// is launched, runs 32 quotient bits in the radix-2 divider, then writes back.
// Throughput: non-divide instructions issue every cycle, since the register
// file forwards a write to a read of the same entry in the same cycle; a
// divide keeps busy high until its result beat is registered, and the next
// instruction is taken at the edge after that.
// Reset (rst_n low, synchronous) clears the control state and marks every
// register as zero through per-entry valid bits; no clearing pass is needed.
module register_file_alu_execute
  import rfe_pkg::*;
#(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [IDX_W-1:0]  in_src_a,
  input  logic [IDX_W-1:0]  in_src_b,
  input  logic [IDX_W-1:0]  in_dest,
  input  logic [DATA_W-1:0] in_literal,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_written_value,
  output logic              out_bad_command,
  output logic              out_divide_by_zero
);

  localparam int AW = $clog2(REG_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV
  } state_t;

  function automatic logic [AW-1:0] wrap_idx(input logic [IDX_W-1:0] raw);
    logic [IDX_W-1:0] v;
    v = raw;
    for (int i = 0; i < 8; i++) begin
      if (int'(v) >= REG_COUNT) begin
        v = v - IDX_W'(REG_COUNT);
      end
    end
    return AW'(v);
  endfunction

  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [AW-1:0]     dest_r;
  logic [DATA_W-1:0] lit_r;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic              out_bad_r, out_bad_nxt;
  logic              out_dz_r, out_dz_nxt;

  logic              accept;
  logic [DATA_W-1:0] op_a;
  logic [DATA_W-1:0] op_b;
  logic [DATA_W-1:0] alu_val;
  logic              alu_write;
  logic              alu_bad;
  logic              alu_dz;
  logic              alu_div_go;

  logic              wr_en;
  logic [DATA_W-1:0] wr_data;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;

  assign busy   = (state_r == ST_DIV) || ((state_r == ST_EXEC) && (cmd_r == CMD_DIV));
  assign accept = start && !busy;

  rfe_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr_a(wrap_idx(in_src_a)),
    .rd_addr_b(wrap_idx(in_src_b)),
    .rd_data_a(op_a),
    .rd_data_b(op_b),
    .wr_en    (wr_en),
    .wr_addr  (dest_r),
    .wr_data  (wr_data)
  );

  rfe_divider u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(op_a),
    .divisor (op_b),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      dest_r <= wrap_idx(in_dest);
      lit_r  <= in_literal;
    end
  end

  always_comb begin
    alu_val    = '0;
    alu_write  = 1'b1;
    alu_bad    = 1'b0;
    alu_dz     = 1'b0;
    alu_div_go = 1'b0;
    case (cmd_r)
      CMD_LOAD:       alu_val = lit_r;
      CMD_ADD:        alu_val = op_a + op_b;
      CMD_SUB:        alu_val = op_a - op_b;
      CMD_MUL:        alu_val = op_a * op_b;
      CMD_DIV: begin
        alu_write = 1'b0;
        if (op_b == '0) begin
          alu_dz = 1'b1;
        end else begin
          alu_div_go = 1'b1;
        end
      end
      CMD_NOT:        alu_val = {{(DATA_W-1){1'b0}}, (op_a == '0)};
      CMD_EQUAL:      alu_val = {{(DATA_W-1){1'b0}}, (op_a == op_b)};
      CMD_LESS:       alu_val = {{(DATA_W-1){1'b0}}, (op_a < op_b)};
      CMD_LESS_EQUAL: alu_val = {{(DATA_W-1){1'b0}}, (op_a <= op_b)};
      default: begin
        alu_write = 1'b0;
        alu_bad   = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = '0;
    out_bad_nxt   = 1'b0;
    out_dz_nxt    = 1'b0;
    wr_en         = 1'b0;
    wr_data       = alu_val;
    div_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (alu_div_go) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          out_valid_nxt = 1'b1;
          out_value_nxt = alu_write ? alu_val : '0;
          out_bad_nxt   = alu_bad;
          out_dz_nxt    = alu_dz;
          wr_en         = alu_write;
          state_nxt     = accept ? ST_EXEC : ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = div_quo;
          wr_en         = 1'b1;
          wr_data       = div_quo;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r <= out_value_nxt;
    out_bad_r   <= out_bad_nxt;
    out_dz_r    <= out_dz_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_written_value  = out_value_r;
  assign out_bad_command    = out_bad_r;
  assign out_divide_by_zero = out_dz_r;

`ifndef SYNTHESIS
  a_flag_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_bad_command || out_divide_by_zero) |-> out_written_value == '0)
    else $error("flagged beat carries a nonzero value");

  a_simple_retires: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) && (cmd_r != CMD_DIV) |=> out_valid)
    else $error("non-divide instruction did not retire next cycle");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_EXEC) || ($past(state_r) == ST_DIV))
    else $error("result beat without an executing instruction");

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> busy)
    else $error("busy dropped while a divide is in flight");
`endif

endmodule
